// ===== src/sce_pkg.sv =====
// Shared types and constants for the source comment extractor.
// Used by sce_front, sce_queue, sce_back and source_comment_extractor_core.
package sce_pkg;

  // Most results that one input character can cause.
  localparam int MaxRes = 4;
  localparam int ResIdxW = $clog2(MaxRes);
  localparam int ResCntW = $clog2(MaxRes + 1);

  // Default number of result bundles held between the front and the back.
  localparam int QueueDepth = 4;

  // Character codes used by the lexer.
  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChStar = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;

  // Meaning of one result.
  typedef enum logic [1:0] {
    KIND_BODY       = 2'd0,
    KIND_FIRST      = 2'd1,
    KIND_END_CLOSED = 2'd2,
    KIND_END_OPEN   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] ch;
    kind_t      kind;
  } result_t;

  // All results caused by one input character, oldest in entry 0.
  typedef struct packed {
    logic [ResCntW-1:0]     count;
    result_t [MaxRes-1:0]   res;
  } bundle_t;

endpackage

// ===== src/sce_front.sv =====
// Front end of the comment extractor: scan state, mode register and the
// per-character decision that packs all results of one character into a bundle.
// Depends on sce_pkg.
module sce_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 push,
  input  logic                 q_full,
  input  logic [7:0]           text_char,
  input  logic                 text_end,
  output logic                 enq_valid,
  output sce_pkg::bundle_t     enq_bundle
);

  localparam int CntW = sce_pkg::ResCntW;
  localparam int IdxW = sce_pkg::ResIdxW;

  // Lexer context.
  typedef enum logic [3:0] {
    SCAN_CODE   = 4'b0001,
    SCAN_BLOCK  = 4'b0010,
    SCAN_LINE   = 4'b0100,
    SCAN_STRING = 4'b1000
  } scan_t;

  // Character kept back until the next one decides what it is.
  typedef enum logic [6:0] {
    HELD_NONE   = 7'b0000001,
    HELD_SLASH  = 7'b0000010,
    HELD_STAR   = 7'b0000100,
    HELD_BSLASH = 7'b0001000,
    HELD_ESCAPE = 7'b0010000,
    HELD_PAREN  = 7'b0100000,
    HELD_QUOTE  = 7'b1000000
  } held_t;

  logic             pascal_rules;
  scan_t            scan_mode;
  scan_t            scan_mode_next;
  scan_t            scan_mid;
  held_t            held_char;
  held_t            held_char_next;
  logic             quote_is_single;
  logic             quote_is_single_next;
  logic             consumed;
  logic             accept;
  sce_pkg::bundle_t bundle;

  // Append one result to a bundle unless it is already full.
  function automatic sce_pkg::bundle_t add_res(sce_pkg::bundle_t b, logic [7:0] ch,
                                               sce_pkg::kind_t k);
    sce_pkg::bundle_t r;
    r = b;
    if (b.count < CntW'(sce_pkg::MaxRes)) begin
      r.res[b.count[IdxW-1:0]].ch = ch;
      r.res[b.count[IdxW-1:0]].kind = k;
      r.count = b.count + CntW'(1);
    end
    return r;
  endfunction

  assign accept = push && !q_full;

  // First resolve the held character against the new one, then handle the
  // new character on its own if it was not used, then close out the text.
  always_comb begin
    bundle = '0;
    consumed = 1'b0;
    scan_mid = scan_mode;
    held_char_next = HELD_NONE;
    quote_is_single_next = quote_is_single;

    unique case (held_char)
      HELD_SLASH: begin
        if (text_char == sce_pkg::ChSlash) begin
          scan_mid = SCAN_LINE;
          bundle = add_res(bundle, sce_pkg::ChSlash, sce_pkg::KIND_FIRST);
          bundle = add_res(bundle, sce_pkg::ChSlash, sce_pkg::KIND_BODY);
          consumed = 1'b1;
        end else if (!pascal_rules && text_char == sce_pkg::ChStar) begin
          scan_mid = SCAN_BLOCK;
          bundle = add_res(bundle, sce_pkg::ChSlash, sce_pkg::KIND_FIRST);
          bundle = add_res(bundle, sce_pkg::ChStar, sce_pkg::KIND_BODY);
          consumed = 1'b1;
        end
      end
      HELD_PAREN: begin
        if (text_char == sce_pkg::ChStar) begin
          scan_mid = SCAN_BLOCK;
          bundle = add_res(bundle, sce_pkg::ChLparen, sce_pkg::KIND_FIRST);
          bundle = add_res(bundle, sce_pkg::ChStar, sce_pkg::KIND_BODY);
          consumed = 1'b1;
        end
      end
      HELD_STAR: begin
        bundle = add_res(bundle, sce_pkg::ChStar, sce_pkg::KIND_BODY);
        if ((!pascal_rules && text_char == sce_pkg::ChSlash) ||
            (pascal_rules && text_char == sce_pkg::ChRparen)) begin
          bundle = add_res(bundle, text_char, sce_pkg::KIND_BODY);
          bundle = add_res(bundle, sce_pkg::ChNewline, sce_pkg::KIND_BODY);
          scan_mid = SCAN_CODE;
          consumed = 1'b1;
        end
      end
      HELD_BSLASH: begin
        bundle = add_res(bundle, sce_pkg::ChBslash, sce_pkg::KIND_BODY);
        if (text_char == sce_pkg::ChNewline) begin
          bundle = add_res(bundle, sce_pkg::ChNewline, sce_pkg::KIND_BODY);
          consumed = 1'b1;
        end
      end
      HELD_ESCAPE: begin
        consumed = 1'b1;
      end
      HELD_QUOTE: begin
        // A doubled quote stays inside the Pascal string.
        if (text_char == sce_pkg::ChSquote) begin
          consumed = 1'b1;
        end else begin
          scan_mid = SCAN_CODE;
        end
      end
      default: begin
      end
    endcase

    scan_mode_next = scan_mid;
    if (!consumed) begin
      unique case (scan_mid)
        SCAN_CODE: begin
          priority if (text_char == sce_pkg::ChSlash) begin
            held_char_next = HELD_SLASH;
          end else if (pascal_rules && text_char == sce_pkg::ChLparen) begin
            held_char_next = HELD_PAREN;
          end else if (pascal_rules && text_char == sce_pkg::ChLbrace) begin
            scan_mode_next = SCAN_BLOCK;
            bundle = add_res(bundle, sce_pkg::ChLbrace, sce_pkg::KIND_FIRST);
          end else if (text_char == sce_pkg::ChSquote) begin
            scan_mode_next = SCAN_STRING;
            quote_is_single_next = 1'b1;
          end else if (!pascal_rules && text_char == sce_pkg::ChDquote) begin
            scan_mode_next = SCAN_STRING;
            quote_is_single_next = 1'b0;
          end else begin
          end
        end
        SCAN_BLOCK: begin
          priority if (text_char == sce_pkg::ChStar) begin
            held_char_next = HELD_STAR;
          end else if (pascal_rules && text_char == sce_pkg::ChRbrace) begin
            bundle = add_res(bundle, sce_pkg::ChRbrace, sce_pkg::KIND_BODY);
            bundle = add_res(bundle, sce_pkg::ChNewline, sce_pkg::KIND_BODY);
            scan_mode_next = SCAN_CODE;
          end else begin
            bundle = add_res(bundle, text_char, sce_pkg::KIND_BODY);
          end
        end
        SCAN_LINE: begin
          priority if (text_char == sce_pkg::ChNewline) begin
            bundle = add_res(bundle, sce_pkg::ChNewline, sce_pkg::KIND_BODY);
            scan_mode_next = SCAN_CODE;
          end else if (!pascal_rules && text_char == sce_pkg::ChBslash) begin
            held_char_next = HELD_BSLASH;
          end else begin
            bundle = add_res(bundle, text_char, sce_pkg::KIND_BODY);
          end
        end
        SCAN_STRING: begin
          if (pascal_rules) begin
            if (text_char == sce_pkg::ChSquote) begin
              held_char_next = HELD_QUOTE;
            end
          end else begin
            priority if (text_char == (quote_is_single_next ? sce_pkg::ChSquote
                                                            : sce_pkg::ChDquote)) begin
              scan_mode_next = SCAN_CODE;
            end else if (text_char == sce_pkg::ChBslash) begin
              held_char_next = HELD_ESCAPE;
            end else begin
            end
          end
        end
        default: begin
        end
      endcase
    end

    // End of text: flush a held comment character, report open or closed,
    // and return the scan state to its reset value.
    if (text_end) begin
      if (held_char_next == HELD_STAR) begin
        bundle = add_res(bundle, sce_pkg::ChStar, sce_pkg::KIND_BODY);
      end else if (held_char_next == HELD_BSLASH) begin
        bundle = add_res(bundle, sce_pkg::ChBslash, sce_pkg::KIND_BODY);
      end
      if (scan_mode_next == SCAN_BLOCK || scan_mode_next == SCAN_LINE) begin
        bundle = add_res(bundle, sce_pkg::ChNul, sce_pkg::KIND_END_OPEN);
      end else begin
        bundle = add_res(bundle, sce_pkg::ChNul, sce_pkg::KIND_END_CLOSED);
      end
      scan_mode_next = SCAN_CODE;
      held_char_next = HELD_NONE;
      quote_is_single_next = 1'b0;
    end
  end

  // Scan state advances on every input transfer; the rule register loads on cfg_we.
  always_ff @(posedge clk) begin
    if (rst) begin
      pascal_rules <= 1'b0;
      scan_mode <= SCAN_CODE;
      held_char <= HELD_NONE;
      quote_is_single <= 1'b0;
    end else begin
      if (cfg_we) begin
        pascal_rules <= cfg_wdata;
      end
      if (accept) begin
        scan_mode <= scan_mode_next;
        held_char <= held_char_next;
        quote_is_single <= quote_is_single_next;
      end
    end
  end

  // Characters that cause no result leave the queue untouched.
  assign enq_valid = accept && (bundle.count != '0);
  assign enq_bundle = bundle;

  // The last character of a text always yields at least the end result.
  a_end_enqueued: assert property (@(posedge clk) disable iff (rst)
    (accept && text_end) |-> enq_valid)
    else $error("end of text produced no bundle");

endmodule

// ===== src/sce_queue.sv =====
// Small queue of result bundles between the front end and the back end.
// Depends on sce_pkg for the bundle type.
module sce_queue #(
  parameter int DEPTH = sce_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  sce_pkg::bundle_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output sce_pkg::bundle_t rd_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  sce_pkg::bundle_t mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign full = (count == CntW'(DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && rd_valid;
  assign rd_data = mem[rd_ptr];

  // Storage, written at the tail.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("queue fill count beyond depth");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + CntW'(1))
    else $error("queue fill count did not follow a write");

endmodule

// ===== src/sce_back.sv =====
// Back end of the comment extractor: takes one bundle at a time from the
// queue and hands its results out one per transfer. Depends on sce_pkg.
module sce_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  sce_pkg::bundle_t q_data,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_char,
  output logic [1:0]       kind,
  output logic             run_last
);

  localparam int CntW = sce_pkg::ResCntW;
  localparam int IdxW = sce_pkg::ResIdxW;

  sce_pkg::bundle_t hold;
  logic             hold_valid;
  logic [IdxW-1:0]  idx;
  logic             out_take;
  logic             at_last;

  assign empty = !hold_valid;
  assign out_take = pop && hold_valid;
  assign at_last = (CntW'(idx) + CntW'(1)) == hold.count;

  // Load the next bundle when nothing is held or the last result leaves.
  assign q_pop = q_valid && (!hold_valid || (out_take && at_last));

  assign out_char = hold.res[idx].ch;
  assign kind = hold.res[idx].kind;
  assign run_last = at_last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hold <= q_data;
    end
  end

  // Valid flag and position inside the held bundle.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (q_pop) begin
        hold_valid <= 1'b1;
        idx <= '0;
      end else if (out_take) begin
        if (at_last) begin
          hold_valid <= 1'b0;
          idx <= '0;
        end else begin
          idx <= idx + IdxW'(1);
        end
      end
    end
  end

  a_hold_count: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (hold.count != '0 && hold.count <= CntW'(sce_pkg::MaxRes)))
    else $error("held bundle has no results or too many");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> CntW'(idx) < hold.count)
    else $error("result index beyond held bundle");

endmodule

// ===== src/source_comment_extractor_core.sv =====
// Top level of the source comment extractor: front end, bundle queue, back end.
// Depends on sce_pkg, sce_front, sce_queue and sce_back.
//
// Usage: source text enters as one character per transfer on push/full with
// text_char and text_end (set on the last character of a text). Comment
// characters leave as a queue: while empty is low, out_char, kind and run_last
// show the oldest result, which is taken when pop is high. kind marks comment
// bytes, the first byte of a comment, and the end result of a text (closed or
// still open); run_last marks the final result caused by one input character.
// cfg_we/cfg_wdata set the rule set (0 C-like, 1 Pascal); write it only while no
// result is waiting. A new rule set applies from the next character on.
// Throughput: one character per cycle while full is low. Each character becomes
// a bundle of zero to four results in the cycle it is transferred; the back end
// hands out one result per cycle while pop is high, so delimiter bursts of three
// or four results leave one by one. A result passes through the queue and then
// the back end's hold register. When the receiver stalls, bundles collect in a
// QUEUE_DEPTH-entry queue and full rises once it is filled. Reset clears the
// scan state, the queue and the rule register (C-like); no clearing pass is needed.
module source_comment_extractor_core #(
  parameter int QUEUE_DEPTH = sce_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_char,
  input  logic       text_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic [1:0] kind,
  output logic       run_last
);

  logic             enq_valid;
  sce_pkg::bundle_t enq_bundle;
  logic             q_valid;
  logic             q_pop;
  sce_pkg::bundle_t q_data;

  // Scan state and per-character decision.
  sce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push       (push),
    .q_full     (full),
    .text_char  (text_char),
    .text_end   (text_end),
    .enq_valid  (enq_valid),
    .enq_bundle (enq_bundle)
  );

  // Decoupling queue of result bundles.
  sce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (enq_valid),
    .wr_data  (enq_bundle),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  // Serializer onto the result port.
  sce_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_char (out_char),
    .kind     (kind),
    .run_last (run_last)
  );

endmodule

// ===== test/sce_comment_checker.sv =====
// Scoreboard for the source comment extractor: predicts the comment stream.
// Watches the text, result and rule-set ports of the core; depends on sce_pkg.
`timescale 1ns / 100ps

module sce_comment_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] text_char,
  input  logic       text_end,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_char,
  input  logic [1:0] kind,
  input  logic       run_last,
  output int         fail_count,
  output int         pending,
  output int         results_checked
);

  typedef enum logic [1:0] {
    SCAN_CODE,
    SCAN_BLOCK,
    SCAN_LINE,
    SCAN_STRING
  } scan_t;

  typedef enum logic [2:0] {
    HOLD_NONE,
    HOLD_SLASH,
    HOLD_STAR,
    HOLD_BSLASH,
    HOLD_ESCAPE,
    HOLD_PAREN,
    HOLD_QUOTE
  } hold_t;

  typedef struct packed {
    logic [7:0]     ch;
    sce_pkg::kind_t kind;
    logic           last;
  } comment_out_t;

  // Lexer state mirrored from the core, plus the rule-set register.
  scan_t        scan;
  hold_t        hold;
  logic         single_quote;
  logic         pascal;

  // Results of the character being lexed, and everything still owed by the core.
  comment_out_t char_results[sce_pkg::MaxRes];
  int           char_count;
  comment_out_t comment_bytes_due[$];
  comment_out_t want;

  task automatic emit(input logic [7:0] ch, input sce_pkg::kind_t k);
    if (char_count < sce_pkg::MaxRes) begin
      char_results[char_count] = '{ch, k, 1'b0};
      char_count++;
    end
  endtask

  // A character with nothing held in front of it.
  task automatic scan_plain(input logic [7:0] c);
    case (scan)
      SCAN_CODE: begin
        if (c == sce_pkg::ChSlash) hold = HOLD_SLASH;
        else if (pascal && c == sce_pkg::ChLparen) hold = HOLD_PAREN;
        else if (pascal && c == sce_pkg::ChLbrace) begin
          scan = SCAN_BLOCK;
          emit(sce_pkg::ChLbrace, sce_pkg::KIND_FIRST);
        end else if (c == sce_pkg::ChSquote) begin
          scan = SCAN_STRING;
          single_quote = 1'b1;
        end else if (!pascal && c == sce_pkg::ChDquote) begin
          scan = SCAN_STRING;
          single_quote = 1'b0;
        end
      end
      SCAN_BLOCK: begin
        if (c == sce_pkg::ChStar) hold = HOLD_STAR;
        else if (pascal && c == sce_pkg::ChRbrace) begin
          emit(sce_pkg::ChRbrace, sce_pkg::KIND_BODY);
          emit(sce_pkg::ChNewline, sce_pkg::KIND_BODY);
          scan = SCAN_CODE;
        end else emit(c, sce_pkg::KIND_BODY);
      end
      SCAN_LINE: begin
        if (c == sce_pkg::ChNewline) begin
          emit(sce_pkg::ChNewline, sce_pkg::KIND_BODY);
          scan = SCAN_CODE;
        end else if (!pascal && c == sce_pkg::ChBslash) hold = HOLD_BSLASH;
        else emit(c, sce_pkg::KIND_BODY);
      end
      default: begin
        if (pascal) begin
          if (c == sce_pkg::ChSquote) hold = HOLD_QUOTE;
        end else if (c == (single_quote ? sce_pkg::ChSquote : sce_pkg::ChDquote)) begin
          scan = SCAN_CODE;
        end else if (c == sce_pkg::ChBslash) hold = HOLD_ESCAPE;
      end
    endcase
  endtask

  // Settle a held character against the next one; taken is set when c is used up.
  task automatic settle_hold(input hold_t h, input logic [7:0] c, output logic taken);
    taken = 1'b0;
    case (h)
      HOLD_SLASH: begin
        if (c == sce_pkg::ChSlash) begin
          scan = SCAN_LINE;
          emit(sce_pkg::ChSlash, sce_pkg::KIND_FIRST);
          emit(sce_pkg::ChSlash, sce_pkg::KIND_BODY);
          taken = 1'b1;
        end else if (!pascal && c == sce_pkg::ChStar) begin
          scan = SCAN_BLOCK;
          emit(sce_pkg::ChSlash, sce_pkg::KIND_FIRST);
          emit(sce_pkg::ChStar, sce_pkg::KIND_BODY);
          taken = 1'b1;
        end
      end
      HOLD_PAREN: begin
        if (c == sce_pkg::ChStar) begin
          scan = SCAN_BLOCK;
          emit(sce_pkg::ChLparen, sce_pkg::KIND_FIRST);
          emit(sce_pkg::ChStar, sce_pkg::KIND_BODY);
          taken = 1'b1;
        end
      end
      HOLD_STAR: begin
        emit(sce_pkg::ChStar, sce_pkg::KIND_BODY);
        if ((!pascal && c == sce_pkg::ChSlash) || (pascal && c == sce_pkg::ChRparen)) begin
          emit(c, sce_pkg::KIND_BODY);
          emit(sce_pkg::ChNewline, sce_pkg::KIND_BODY);
          scan = SCAN_CODE;
          taken = 1'b1;
        end
      end
      HOLD_BSLASH: begin
        emit(sce_pkg::ChBslash, sce_pkg::KIND_BODY);
        if (c == sce_pkg::ChNewline) begin
          emit(sce_pkg::ChNewline, sce_pkg::KIND_BODY);
          taken = 1'b1;
        end
      end
      HOLD_ESCAPE: taken = 1'b1;
      HOLD_QUOTE: begin
        if (c == sce_pkg::ChSquote) taken = 1'b1;
        else scan = SCAN_CODE;
      end
      default: ;
    endcase
  endtask

  // Lex one transferred character and queue the results it causes.
  task automatic lex_char(input logic [7:0] c, input logic fin);
    hold_t h;
    logic  taken;
    char_count = 0;
    h = hold;
    hold = HOLD_NONE;
    settle_hold(h, c, taken);
    if (!taken) scan_plain(c);
    if (fin) begin
      if (hold == HOLD_STAR) emit(sce_pkg::ChStar, sce_pkg::KIND_BODY);
      else if (hold == HOLD_BSLASH) emit(sce_pkg::ChBslash, sce_pkg::KIND_BODY);
      if (scan == SCAN_BLOCK || scan == SCAN_LINE) begin
        emit(sce_pkg::ChNul, sce_pkg::KIND_END_OPEN);
      end else begin
        emit(sce_pkg::ChNul, sce_pkg::KIND_END_CLOSED);
      end
      scan = SCAN_CODE;
      hold = HOLD_NONE;
      single_quote = 1'b0;
    end
    if (char_count > 0) char_results[char_count-1].last = 1'b1;
    for (int i = 0; i < char_count; i++) comment_bytes_due.push_back(char_results[i]);
  endtask

  // Check result transfers against the oldest prediction, then predict new ones.
  always @(posedge clk) begin
    if (rst) begin
      scan = SCAN_CODE;
      hold = HOLD_NONE;
      single_quote = 1'b0;
      pascal = 1'b0;
      comment_bytes_due.delete();
      fail_count = 0;
      results_checked = 0;
    end else begin
      if (pop && !empty) begin
        if (comment_bytes_due.size() == 0) begin
          $error("result with none expected: out_char %h kind %0d run_last %b",
                 out_char, kind, run_last);
          fail_count++;
        end else begin
          want = comment_bytes_due.pop_front();
          results_checked++;
          if (out_char !== want.ch) begin
            $error("out_char: expected %h, actual %h", want.ch, out_char);
            fail_count++;
          end
          if (kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind);
            fail_count++;
          end
          if (run_last !== want.last) begin
            $error("run_last: expected %b, actual %b", want.last, run_last);
            fail_count++;
          end
        end
      end
      if (push && !full) lex_char(text_char, text_end);
      if (cfg_we) pascal = cfg_wdata;
    end
    pending = comment_bytes_due.size();
  end

endmodule

// ===== test/tb_source_comment_extractor_core.sv =====
// Testbench top for source_comment_extractor_core: drives source text and rule sets.
// Instantiates the core and sce_comment_checker; depends on sce_pkg.
`timescale 1ns / 100ps

module tb_source_comment_extractor_core;

  localparam int StallLimit = 2000;
  localparam int PhaseCount = 6;
  localparam int PhaseChars = 72;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       push;
  logic       full;
  logic [7:0] text_char;
  logic       text_end;
  logic       empty;
  logic       pop;
  logic [7:0] out_char;
  logic [1:0] kind;
  logic       run_last;

  int         fail_count;
  int         pending;
  int         results_checked;

  int         chars_sent;
  int         texts_sent;
  int         mode_writes;
  int         idle_run;
  logic       pascal_now;
  logic       sender_gaps_on;
  logic       receiver_stalls_on;
  logic [7:0] text_q[$];

  source_comment_extractor_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .full      (full),
    .text_char (text_char),
    .text_end  (text_end),
    .empty     (empty),
    .pop       (pop),
    .out_char  (out_char),
    .kind      (kind),
    .run_last  (run_last)
  );

  sce_comment_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .push            (push),
    .full            (full),
    .text_char       (text_char),
    .text_end        (text_end),
    .empty           (empty),
    .pop             (pop),
    .out_char        (out_char),
    .kind            (kind),
    .run_last        (run_last),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: takes results every cycle, with random stall bursts when enabled.
  initial begin
    pop <= 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (receiver_stalls_on && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin
    idle_run = 0;
    while (idle_run < StallLimit) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) idle_run = 0;
      else idle_run++;
    end
    $error("no transfer for %0d cycles", StallLimit);
    $display("tb_source_comment_extractor_core failed");
    $finish;
  end

  task automatic idle_sender(input int cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // One character transfer; decides at the falling edge whether the core takes it.
  task automatic send_char(input logic [7:0] c, input logic fin);
    logic taken;
    if (sender_gaps_on && $urandom_range(0, 11) == 0) idle_sender($urandom_range(1, 11));
    push <= 1'b1;
    text_char <= c;
    text_end <= fin;
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    chars_sent++;
  endtask

  task automatic send_str(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_char(s[i], fin && i == s.len() - 1);
  endtask

  // Hold the sender off until every predicted result has been transferred.
  task automatic drain_results();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Rule-set write once the core is idle; waits out the pipeline first.
  task automatic write_rules(input logic pascal);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= pascal;
    @(posedge clk);
    cfg_we <= 1'b0;
    pascal_now = pascal;
    mode_writes++;
  endtask

  // Characters biased toward delimiters, quotes and escapes.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return sce_pkg::ChSlash;
    else if (r < 20) return sce_pkg::ChStar;
    else if (r < 26) return sce_pkg::ChNewline;
    else if (r < 32) return sce_pkg::ChBslash;
    else if (r < 38) return sce_pkg::ChDquote;
    else if (r < 44) return sce_pkg::ChSquote;
    else if (r < 50) return sce_pkg::ChLparen;
    else if (r < 54) return sce_pkg::ChRparen;
    else if (r < 58) return sce_pkg::ChLbrace;
    else if (r < 62) return sce_pkg::ChRbrace;
    else if (r < 85) return 8'(97 + $urandom_range(0, 25));
    else return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_body(input int n);
    repeat (n) text_q.push_back(pick_char());
  endtask

  // Mostly well-formed comments and strings of the current rules, with noise.
  task automatic build_text();
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            if (!pascal_now) add_str("/*");
            else if ($urandom_range(0, 1) == 1) add_str("(*");
            else add_str("{");
            add_body($urandom_range(0, 8));
            if (!pascal_now) add_str("*/");
            else if ($urandom_range(0, 1) == 1) add_str("*)");
            else add_str("}");
          end
          3, 4: begin
            add_str("//");
            add_body($urandom_range(0, 6));
            if (!pascal_now && $urandom_range(0, 2) == 0) begin
              add_str("\\\n");
              add_body($urandom_range(0, 4));
            end
            if ($urandom_range(0, 9) != 0) add_str("\n");
          end
          5: begin
            if (pascal_now) begin
              add_str("'");
              add_body($urandom_range(0, 4));
              if ($urandom_range(0, 1) == 1) add_str("''");
              add_str("'");
            end else if ($urandom_range(0, 1) == 1) begin
              add_str("\"");
              add_body($urandom_range(0, 5));
              add_str("\"");
            end else begin
              add_str("'");
              add_body($urandom_range(0, 3));
              add_str("'");
            end
          end
          default: add_body($urandom_range(1, 6));
        endcase
      end
    end
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    texts_sent++;
  endtask

  initial begin
    int phase_chars;
    chars_sent = 0;
    texts_sent = 0;
    mode_writes = 0;
    pascal_now = 1'b0;
    sender_gaps_on = 1'b0;
    receiver_stalls_on = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    push <= 1'b0;
    text_char <= 8'h00;
    text_end <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: C rules after reset, star runs, top byte value.
    send_str("/*", 1'b0);
    send_char(8'hFF, 1'b0);
    send_str("**/", 1'b1);
    // String escape, line comment with a zero byte, continuation, open at the end.
    send_str("\"\\\"\"//", 1'b0);
    send_char(8'h00, 1'b0);
    send_str("\\\nk", 1'b1);
    // Rules switched while a star is held: the Pascal closer finishes the comment.
    send_str("/*y*", 1'b0);
    write_rules(1'b1);
    send_str(")", 1'b1);
    // Pascal braces, broken paren opener, doubled quote, line comment left open.
    send_str("{*}(x''''//*", 1'b1);
    // Paren-star comment ending on a held star.
    send_str("(*", 1'b0);
    send_char(8'hFF, 1'b0);
    send_str("*", 1'b1);

    // Random phases; the last one runs with no idling on either side.
    for (int p = 0; p < PhaseCount; p++) begin
      if (p < 4) write_rules(p % 2 == 1);
      else write_rules($urandom_range(0, 1) == 1);
      sender_gaps_on = (p < PhaseCount - 1) && ($urandom_range(0, 3) != 0);
      receiver_stalls_on <= (p < PhaseCount - 1) && ($urandom_range(0, 3) != 0);
      phase_chars = 0;
      while (phase_chars < PhaseChars) begin
        build_text();
        send_text();
        phase_chars += text_q.size();
        if ((p < PhaseCount - 1) &&
            ((p == 0 && phase_chars == text_q.size()) || $urandom_range(0, 7) == 0))
          drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d characters in %0d texts under C and Pascal rules, %0d rule writes.",
             chars_sent, texts_sent, mode_writes);
    $display("Checked %0d comment results with random stalls on both sides.",
             results_checked);
    if (fail_count == 0) $display("tb_source_comment_extractor_core passed");
    else $display("tb_source_comment_extractor_core failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/sce_pkg.sv
src/sce_front.sv
src/sce_queue.sv
src/sce_back.sv
src/source_comment_extractor_core.sv
test/sce_comment_checker.sv
test/tb_source_comment_extractor_core.sv
